// ----- rtl/sidht_pkg.sv -----
// Shared types and codes for the short id hash table.
// Used by the controller, the datapath and the top level.
package sidht_pkg;

    localparam int ID_W     = 48;
    localparam int CNT_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int IB_W     = 5;
    localparam int IN_DATA_W  = ID_W + CNT_W + HANDLE_W + LEN_W;
    localparam int OUT_DATA_W = HANDLE_W + LEN_W;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

    localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_BEGUN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd6;

    typedef struct packed {
        logic                capture;
        logic                clear_init;
        logic                clear_step;
        logic                begin_exec;
        logic                hash_init;
        logic                hash_step;
        logic                probe_init;
        logic                probe_read;
        logic                probe_next;
        logic                write_slot;
        logic                write_dup;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              clear_done;
        logic              wrap;
        logic              ignore;
        logic              full;
        logic              hash_done;
        logic              slot_live;
        logic              id_match;
        logic              slot_dup;
        logic              probe_last;
        logic              out_free;
    } stat_t;

endpackage

// ----- rtl/sidht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sidht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sidht_ctrl.sv -----
// Sequencing state machine for the short id hash table.
// Depends on sidht_pkg; drives the datapath through cmd_t, reads stat_t.
module sidht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output sidht_pkg::cmd_t   cmd,
    input  sidht_pkg::stat_t  stat
);
    import sidht_pkg::*;

    typedef enum logic [8:0] {
        S_INIT_CLR    = 9'b000000001,
        S_IDLE        = 9'b000000010,
        S_DECODE      = 9'b000000100,
        S_WRAP_CLR    = 9'b000001000,
        S_HASH        = 9'b000010000,
        S_PROBE_START = 9'b000100000,
        S_PROBE_RD    = 9'b001000000,
        S_PROBE_CHK   = 9'b010000000,
        S_RESP        = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT_CLR;
            status_reg <= ST_BEGUN;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.hash_init = 1'b1;
                unique case (stat.kind)
                    KIND_BEGIN:
                    begin
                        cmd.begin_exec = 1'b1;
                        status_next    = ST_BEGUN;
                        if (stat.wrap)
                        begin
                            cmd.clear_init = 1'b1;
                            state_next     = S_WRAP_CLR;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (stat.ignore)
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_RESP;
                        end
                        else if (stat.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_HASH;
                        end
                    end
                    KIND_LOOKUP:
                    begin
                        state_next = S_HASH;
                    end
                    default:
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_RESP;
                    end
                endcase
            end
            S_WRAP_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_done)
                begin
                    state_next = S_PROBE_START;
                end
            end
            S_PROBE_START:
            begin
                cmd.probe_init = 1'b1;
                state_next     = S_PROBE_RD;
            end
            S_PROBE_RD:
            begin
                cmd.probe_read = 1'b1;
                state_next     = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                state_next = S_RESP;
                if (stat.kind == KIND_INSERT)
                begin
                    if (!stat.slot_live)
                    begin
                        cmd.write_slot = 1'b1;
                        status_next    = ST_INSERTED;
                    end
                    else if (stat.id_match)
                    begin
                        cmd.write_dup = 1'b1;
                        status_next   = ST_DUP;
                    end
                    else if (stat.probe_last)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PROBE_RD;
                    end
                end
                else
                begin
                    if (!stat.slot_live)
                    begin
                        status_next = ST_MISS;
                    end
                    else if (stat.id_match)
                    begin
                        status_next = stat.slot_dup ? ST_MISS : ST_FOUND;
                    end
                    else if (stat.probe_last)
                    begin
                        status_next = ST_MISS;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_PROBE_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sidht_dp.sv -----
// Datapath: item capture, multi-cycle hash, probe pointer, slot RAM, result register.
// Depends on sidht_pkg and sidht_ram; steered by sidht_ctrl.
module sidht_dp #(
    parameter int MAX_INDEX_BITS = 16,
    parameter int MIN_INDEX_BITS = 12,
    parameter int STAMP_BITS     = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [sidht_pkg::IN_DATA_W-1:0]      in_data,
    input  logic [sidht_pkg::KIND_W-1:0]         in_kind,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sidht_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [sidht_pkg::STATUS_W-1:0]       out_status,
    input  sidht_pkg::cmd_t                      cmd,
    output sidht_pkg::stat_t                     stat
);
    import sidht_pkg::*;

    localparam int IW     = MAX_INDEX_BITS;
    localparam int SB     = STAMP_BITS;
    localparam int DEPTH  = 1 << IW;
    localparam int WORD_W = SB + ID_W + HANDLE_W + LEN_W + 1;

    // captured item
    logic [KIND_W-1:0]   kind_reg;
    logic [ID_W-1:0]     id_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LEN_W-1:0]    len_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            id_reg     <= in_data[ID_W-1:0];
            cnt_reg    <= in_data[ID_W +: CNT_W];
            handle_reg <= in_data[ID_W+CNT_W +: HANDLE_W];
            len_reg    <= in_data[ID_W+CNT_W+HANDLE_W +: LEN_W];
        end
    end

    // generation and table size
    logic [SB-1:0]   stamp_reg;
    logic [IB_W-1:0] ib_reg;
    logic [IW-1:0]   mask_reg;
    logic [IW:0]     live_reg;
    logic [IB_W-1:0] ib_next;
    logic [IW:0]     one_sh;
    logic [IW-1:0]   mask_next;
    logic [CNT_W:0]  cnt2;

    assign cnt2 = {cnt_reg, 1'b0};

    always_comb
    begin
        ib_next = IB_W'(MAX_INDEX_BITS);
        for (int bb = MAX_INDEX_BITS - 1; bb >= MIN_INDEX_BITS; bb--)
        begin
            if (((CNT_W+1)'(1) << bb) >= cnt2)
            begin
                ib_next = IB_W'(bb);
            end
        end
        one_sh    = (IW+1)'(1) << ib_next;
        mask_next = IW'(one_sh - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg <= '0;
            ib_reg    <= IB_W'(MAX_INDEX_BITS);
            mask_reg  <= '1;
            live_reg  <= '0;
        end
        else if (cmd.begin_exec)
        begin
            stamp_reg <= (&stamp_reg) ? SB'(1) : stamp_reg + 1'b1;
            ib_reg    <= ib_next;
            mask_reg  <= mask_next;
            live_reg  <= '0;
        end
        else if (cmd.write_slot)
        begin
            live_reg <= live_reg + 1'b1;
        end
    end

    // clearing sweep of the slot RAM (whole words written to zero)
    logic [IW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_init)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // hash: four 24x32 partial products accumulated mod 2^64
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic [23:0] pa;
    logic [31:0] pg;
    logic [55:0] prod;
    logic [5:0]  sh;

    always_comb
    begin
        pa   = step_reg[1] ? id_reg[47:24] : id_reg[23:0];
        pg   = step_reg[0] ? GOLDEN[63:32] : GOLDEN[31:0];
        prod = 56'(pa) * 56'(pg);
        case (step_reg)
            2'd0:    sh = 6'd0;
            2'd1:    sh = 6'd32;
            2'd2:    sh = 6'd24;
            default: sh = 6'd56;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_init)
        begin
            acc_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            acc_reg  <= acc_reg + (64'(prod) << sh);
            step_reg <= step_reg + 1'b1;
        end
    end

    // probe pointer
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] n_reg;
    logic [IW-1:0] home;
    logic [6:0]    hsh;

    assign hsh  = 7'd64 - 7'(ib_reg);
    assign home = IW'(acc_reg >> hsh);

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            idx_reg <= home;
            n_reg   <= '0;
        end
        else if (cmd.probe_next)
        begin
            idx_reg <= (idx_reg + 1'b1) & mask_reg;
            n_reg   <= n_reg + 1'b1;
        end
    end

    // slot RAM: {dup, length, handle, id, stamp}
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   wr_word;
    logic [IW-1:0]       wr_addr;
    logic                wr_en;
    logic [SB-1:0]       rd_stamp;
    logic [ID_W-1:0]     rd_id;
    logic [HANDLE_W-1:0] rd_handle;
    logic [LEN_W-1:0]    rd_len;
    logic                rd_dup;

    assign {rd_dup, rd_len, rd_handle, rd_id, rd_stamp} = rd_word;

    always_comb
    begin
        wr_en   = cmd.clear_step | cmd.write_slot | cmd.write_dup;
        wr_addr = cmd.clear_step ? clr_reg : idx_reg;
        if (cmd.clear_step)
        begin
            wr_word = '0;
        end
        else if (cmd.write_slot)
        begin
            wr_word = {1'b0, len_reg, handle_reg, id_reg, stamp_reg};
        end
        else
        begin
            wr_word = {1'b1, rd_len, rd_handle, rd_id, rd_stamp};
        end
    end

    sidht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_word),
        .re    (cmd.probe_read),
        .raddr (idx_reg),
        .rdata (rd_word)
    );

    // result register
    logic                  ov_reg;
    logic [OUT_DATA_W-1:0] od_reg;
    logic [STATUS_W-1:0]   os_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            os_reg <= cmd.out_status;
            od_reg <= (cmd.out_status == ST_FOUND) ? {rd_len, rd_handle} : '0;
        end
    end

    assign out_valid  = ov_reg;
    assign out_data   = od_reg;
    assign out_status = os_reg;

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.clear_done = &clr_reg;
        stat.wrap       = &stamp_reg;
        stat.ignore     = (len_reg == '0) || (stamp_reg == '0);
        stat.full       = live_reg >= {1'b0, mask_reg};
        stat.hash_done  = &step_reg;
        stat.slot_live  = (stamp_reg != '0) && (rd_stamp == stamp_reg);
        stat.id_match   = rd_id == id_reg;
        stat.slot_dup   = rd_dup;
        stat.probe_last = n_reg == mask_reg;
        stat.out_free   = !ov_reg || out_ready;
    end

endmodule

// ----- rtl/short_id_hash_table.sv -----
// Short id hash table: open addressing, linear probing, generation stamps.
// Begin: starts a new generation; on stamp wrap all 2^MAX_INDEX_BITS slots are cleared first.
// Insert/lookup: hash, then probe slots (one slot RAM read per probe); ignored or
// full inserts and unknown kinds skip hash and probe. Next item taken only after the result is loaded.
// Reset: slot RAM cleared one entry per cycle over all 2^MAX_INDEX_BITS entries, no items taken.
module short_id_hash_table #(
    parameter int MAX_INDEX_BITS = 16,
    parameter int MIN_INDEX_BITS = 12,
    parameter int STAMP_BITS     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // short_id, pool_count, tx_handle, tx_length
    input  logic [sidht_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [sidht_pkg::KIND_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // found_handle, found_length
    output logic [sidht_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [sidht_pkg::STATUS_W-1:0]      m_tuser
);
    import sidht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sidht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sidht_dp #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .MIN_INDEX_BITS (MIN_INDEX_BITS),
        .STAMP_BITS     (STAMP_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (s_tdata),
        .in_kind    (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule
